// File: src/box_blur_3x3_rgb_core_macros.svh
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_core assertion macros
// Shared property wrappers: clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_CORE_MACROS_SVH
`define BOX_BLUR_3X3_RGB_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bb3_pkg.sv
// ---------------------------------------------------------------------------
// bb3_pkg
// Types, constants and the rounded mean shared by the box blur blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

   localparam int PIX_W   = 8;
   localparam int FW_W    = 11;
   localparam int FH_W    = 13;
   localparam int CSR_W   = 13;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W   = 12;   // 9 * 255 fits
   localparam int NUM_W   = SUM_W + 1;
   localparam int COUNT_W = 4;

   // reciprocals for thirds and ninths, exact for dividends below 32768
   localparam int RECIP_SH = 16;
   localparam int PROD_W   = NUM_W + RECIP_SH;
   localparam logic [RECIP_SH-1:0] RECIP_3 = 16'd21846;
   localparam logic [RECIP_SH-1:0] RECIP_9 = 16'd7282;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   // operation codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } sum_type;

   // which neighbor rows and columns lie inside the frame
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } edge_mask_type;

   // (2*sum + count) / (2*count), halves round up; shift off the power of
   // two, then multiply by the reciprocal of the odd factor
   function automatic logic [PIX_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                   input logic [COUNT_W-1:0] count);
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  quo;
      logic [PROD_W-1:0] prod;
      num  = {sum, 1'b0} + NUM_W'(count);
      prod = '0;
      quo  = '0;
      case (count)
         4'd1: begin
            quo = num >> 1;
         end
         4'd2: begin
            quo = num >> 2;
         end
         4'd3: begin
            prod = PROD_W'(num >> 1) * PROD_W'(RECIP_3);
            quo  = prod[RECIP_SH +: NUM_W];
         end
         4'd4: begin
            quo = num >> 3;
         end
         4'd6: begin
            prod = PROD_W'(num >> 2) * PROD_W'(RECIP_3);
            quo  = prod[RECIP_SH +: NUM_W];
         end
         4'd9: begin
            prod = PROD_W'(num >> 1) * PROD_W'(RECIP_9);
            quo  = prod[RECIP_SH +: NUM_W];
         end
         default: begin
            quo = '0;
         end
      endcase
      return quo[PIX_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: src/bb3_ram.sv
// ---------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/bb3_window.sv
// ---------------------------------------------------------------------------
// bb3_window
// 3x3 pixel window: shifts in one column per transfer and gives the masked
// per-channel sums and the neighbor count of the shifted window.
// ---------------------------------------------------------------------------
`default_nettype none

module bb3_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              shift_en,
   input  bb3_pkg::rgb_type                  col_top,
   input  bb3_pkg::rgb_type                  col_mid,
   input  bb3_pkg::rgb_type                  col_bot,
   input  bb3_pkg::edge_mask_type            mask,
   output bb3_pkg::sum_type                  sum_out,
   output logic [bb3_pkg::COUNT_W-1:0]       count_out
);

   bb3_pkg::rgb_type win_ff [3][3];
   bb3_pkg::rgb_type win_in [3][3];
   logic [2:0]       row_use;
   logic [2:0]       col_use;
   logic [1:0]       n_rows;
   logic [1:0]       n_cols;

   // shift left, new column enters on the right
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 2; c++) begin
            win_in[r][c] = win_ff[r][c+1];
         end
      end
      win_in[0][2] = col_top;
      win_in[1][2] = col_mid;
      win_in[2][2] = col_bot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      row_use = {mask.bottom, 1'b1, mask.top};
      col_use = {mask.right, 1'b1, mask.left};
      sum_out = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (row_use[r] && col_use[c]) begin
               sum_out.red   = sum_out.red   + bb3_pkg::SUM_W'(win_in[r][c].red);
               sum_out.green = sum_out.green + bb3_pkg::SUM_W'(win_in[r][c].green);
               sum_out.blue  = sum_out.blue  + bb3_pkg::SUM_W'(win_in[r][c].blue);
            end
         end
      end
   end

   assign n_rows    = 2'd1 + 2'(mask.top) + 2'(mask.bottom);
   assign n_cols    = 2'd1 + 2'(mask.left) + 2'(mask.right);
   assign count_out = bb3_pkg::COUNT_W'(n_rows) * bb3_pkg::COUNT_W'(n_cols);

endmodule

`default_nettype wire

// File: src/box_blur_3x3_rgb_core.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 box blur, edge-normalized, round half up.
// Throughput: one item per cycle unless the output stalls. A result follows
// the transfer of the item that completes its window (pixel q + width + 1).
// Path: line store read, window sum, rounded mean register.
// Reset: synchronous; counters, valids and window clear, while the
// line stores need no clearing pass. Frame size resets to 640 x 480.
// ---------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [bb3_pkg::PIX_W-1:0]         req_in_red,
   input  logic [bb3_pkg::PIX_W-1:0]         req_in_green,
   input  logic [bb3_pkg::PIX_W-1:0]         req_in_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bb3_pkg::PIX_W-1:0]         rsp_out_red,
   output logic [bb3_pkg::PIX_W-1:0]         rsp_out_green,
   output logic [bb3_pkg::PIX_W-1:0]         rsp_out_blue,
   output logic                              rsp_frame_end,
   input  logic                              csr_write,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bb3_pkg::CSR_W-1:0]         csr_wdata
);

`include "box_blur_3x3_rgb_core_macros.svh"

   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = $clog2(MAX_HEIGHT + 2);
   localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
   localparam int H_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

   // frame size, stored as last column / last row
   logic [CW-1:0] w_last_ff, w_last_in;
   logic [RW-1:0] h_last_ff, h_last_in;
   logic [bb3_pkg::FW_W-1:0] wr_width;
   logic [bb3_pkg::FH_W-1:0] wr_height;

   // position counters
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;

   logic req_xfer, flushing, ignore, take, emit, frame_last;
   bb3_pkg::rgb_type      req_pix;
   bb3_pkg::edge_mask_type mask_now;

   // stage 1: line store read
   logic                   s1_valid_ff, s1_valid_in;
   bb3_pkg::rgb_type       s1_pix_ff;
   logic [CW-1:0]          s1_col_ff;
   logic                   s1_emit_ff;
   logic                   s1_last_ff;
   bb3_pkg::edge_mask_type s1_mask_ff;
   logic                   s1_byp_ff, s1_byp_in;
   bb3_pkg::rgb_type       s1_byp_top_ff;
   bb3_pkg::rgb_type       s1_byp_mid_ff;
   logic                   s1_adv;
   logic [23:0]            upper_q, middle_q;
   bb3_pkg::rgb_type       top_eff, mid_eff;

   // stage 2: window sums
   logic                         s2_valid_ff, s2_valid_in;
   bb3_pkg::sum_type             s2_sum_ff;
   logic [bb3_pkg::COUNT_W-1:0]  s2_count_ff;
   logic                         s2_last_ff;
   logic                         s2_adv;
   bb3_pkg::sum_type             win_sum;
   logic [bb3_pkg::COUNT_W-1:0]  win_count;

   // stage 3: result register
   logic             rsp_valid_ff, rsp_valid_in;
   bb3_pkg::rgb_type rsp_pix_ff;
   logic             rsp_last_ff;

   // ---------------- configuration ----------------
   assign wr_width  = csr_wdata[bb3_pkg::FW_W-1:0];
   assign wr_height = csr_wdata[bb3_pkg::FH_W-1:0];

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_write && csr_index == bb3_pkg::REG_FRAME_WIDTH) begin
         if (wr_width == '0) begin
            w_last_in = '0;
         end else if (32'(wr_width) > MAX_WIDTH) begin
            w_last_in = CW'(MAX_WIDTH - 1);
         end else begin
            w_last_in = CW'(32'(wr_width) - 32'd1);
         end
      end
      if (csr_write && csr_index == bb3_pkg::REG_FRAME_HEIGHT) begin
         if (wr_height == '0) begin
            h_last_in = '0;
         end else if (32'(wr_height) > MAX_HEIGHT) begin
            h_last_in = RW'(MAX_HEIGHT - 1);
         end else begin
            h_last_in = RW'(32'(wr_height) - 32'd1);
         end
      end
   end

   // ---------------- stage 0: accept and count ----------------
   assign req_xfer   = req_valid && !req_stall;
   assign flushing   = in_row_ff > h_last_ff;
   assign ignore     = !flushing && (req_operation == bb3_pkg::OP_DRAIN);
   assign take       = req_xfer && !ignore;
   assign emit       = (in_row_ff != '0) && ((in_row_ff != RW'(1)) || (in_col_ff != '0));
   assign frame_last = emit && (out_row_ff == h_last_ff) && (out_col_ff == w_last_ff);

   always_comb begin
      if (flushing) begin
         req_pix = '0;
      end else begin
         req_pix = '{red: req_in_red, green: req_in_green, blue: req_in_blue};
      end
      mask_now.top    = out_row_ff != '0;
      mask_now.bottom = out_row_ff != h_last_ff;
      mask_now.left   = out_col_ff != '0;
      mask_now.right  = out_col_ff != w_last_ff;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write) begin
         // any register write starts a new frame
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (frame_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (in_col_ff == w_last_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RW'(1);
            end else begin
               in_col_in = in_col_ff + CW'(1);
            end
            if (emit) begin
               if (out_col_ff == w_last_ff) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + RW'(1);
               end else begin
                  out_col_in = out_col_ff + CW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff  <= CW'(W_RST - 1);
         h_last_ff  <= RW'(H_RST - 1);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         w_last_ff  <= w_last_in;
         h_last_ff  <= h_last_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------- line stores ----------------
   bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_eff),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (upper_q)
   );

   bb3_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH), .AW(CW)) u_middle (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (middle_q)
   );

   // ---------------- stage 1 ----------------
   // forward the write that lands in the same cycle as the read
   assign top_eff = s1_byp_ff ? s1_byp_top_ff : bb3_pkg::rgb_type'(upper_q);
   assign mid_eff = s1_byp_ff ? s1_byp_mid_ff : bb3_pkg::rgb_type'(middle_q);

   assign s2_adv    = s2_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_stall = s1_valid_ff && !s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      s1_byp_in = s1_byp_ff;
      if (take) begin
         s1_byp_in = s1_adv && (s1_col_ff == in_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_byp_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_byp_ff   <= s1_byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_pix_ff     <= req_pix;
         s1_col_ff     <= in_col_ff;
         s1_emit_ff    <= emit;
         s1_last_ff    <= frame_last;
         s1_mask_ff    <= mask_now;
         s1_byp_top_ff <= mid_eff;
         s1_byp_mid_ff <= s1_pix_ff;
      end
   end

   bb3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_adv),
      .col_top   (top_eff),
      .col_mid   (mid_eff),
      .col_bot   (s1_pix_ff),
      .mask      (s1_mask_ff),
      .sum_out   (win_sum),
      .count_out (win_count)
   );

   // ---------------- stage 2 ----------------
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = s1_emit_ff;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_sum_ff   <= win_sum;
         s2_count_ff <= win_count;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // ---------------- stage 3: result ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_pix_ff.red   <= bb3_pkg::round_mean(s2_sum_ff.red, s2_count_ff);
         rsp_pix_ff.green <= bb3_pkg::round_mean(s2_sum_ff.green, s2_count_ff);
         rsp_pix_ff.blue  <= bb3_pkg::round_mean(s2_sum_ff.blue, s2_count_ff);
         rsp_last_ff      <= s2_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_pix_ff.red;
   assign rsp_out_green = rsp_pix_ff.green;
   assign rsp_out_blue  = rsp_pix_ff.blue;
   assign rsp_frame_end = rsp_last_ff;

   // ---------------- assertions ----------------
   `BB3_ASSERT_SAME(a_stall_needs_s1, req_stall, s1_valid_ff, "input stalled with stage 1 empty")
   `BB3_ASSERT_SAME(a_in_col_range, 1'b1, in_col_ff <= w_last_ff, "input column past frame width")
   `BB3_ASSERT_SAME(a_out_col_range, 1'b1, out_col_ff <= w_last_ff, "output column past frame width")
   `BB3_ASSERT_SAME(a_in_row_range, 1'b1, (RW+1)'(in_row_ff) <= (RW+1)'(h_last_ff) + (RW+1)'(2), "input row past flush rows")
   `BB3_ASSERT_SAME(a_count_legal, s2_valid_ff, (s2_count_ff == 4'd1) || (s2_count_ff == 4'd2) || (s2_count_ff == 4'd3) || (s2_count_ff == 4'd4) || (s2_count_ff == 4'd6) || (s2_count_ff == 4'd9), "illegal neighbor count")

endmodule

`default_nettype wire

// File: verif/box_blur_3x3_rgb_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_blur_3x3_rgb_core_tb
// Streams RGB frames of many sizes through the blur core and checks every
// blurred pixel against a cycle-free predictor kept in the bench. Covers
// corners, edges, one-row and one-column frames, zero and oversized frame
// size writes, ignored drain ticks, pixels dropped during the flush and a
// long output hold-off that backs up the input.
// ---------------------------------------------------------------------------

module box_blur_3x3_rgb_core_tb;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 4096;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 40;
   localparam int LIMIT_CYCLES  = 800000;

   typedef enum int {IDLE_MOSTLY_RX, IDLE_MOSTLY_TX, IDLE_NONE} idle_mode_type;

   typedef struct packed {
      logic             op;
      bb3_pkg::rgb_type pix;
   } pixel_item_type;

   typedef struct packed {
      bb3_pkg::rgb_type color;
      logic             frame_end;
   } blurred_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid     = 1'b0;
   logic                            req_stall;
   logic                            req_operation = bb3_pkg::OP_PIXEL;
   logic [bb3_pkg::PIX_W-1:0]       req_in_red    = '0;
   logic [bb3_pkg::PIX_W-1:0]       req_in_green  = '0;
   logic [bb3_pkg::PIX_W-1:0]       req_in_blue   = '0;
   logic                            rsp_valid;
   logic                            rsp_stall     = 1'b0;
   logic [bb3_pkg::PIX_W-1:0]       rsp_out_red;
   logic [bb3_pkg::PIX_W-1:0]       rsp_out_green;
   logic [bb3_pkg::PIX_W-1:0]       rsp_out_blue;
   logic                            rsp_frame_end;
   logic                            csr_write     = 1'b0;
   logic [bb3_pkg::CSR_IDX_W-1:0]   csr_index     = '0;
   logic [bb3_pkg::CSR_W-1:0]       csr_wdata     = '0;

   pixel_item_type pending_q[$];
   blurred_type    blurred_q[$];

   idle_mode_type idle_mode = IDLE_MOSTLY_RX;
   int            hold_req  = 0;
   int            hold_seen = 0;
   int            hold_left = 0;
   int            fail_count    = 0;
   int            checked_count = 0;
   int            cycle_count   = 0;

   // predictor state
   bb3_pkg::rgb_type          upper_rows [MAX_W];
   bb3_pkg::rgb_type          middle_rows[MAX_W];
   bb3_pkg::rgb_type          win[9];
   int unsigned               in_col;
   int unsigned               in_row;
   int unsigned               out_idx;
   logic [bb3_pkg::FW_W-1:0]  width_reg;
   logic [bb3_pkg::FH_W-1:0]  height_reg;

   box_blur_3x3_rgb_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic chance(input int unsigned pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_idx = 0;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_REPORTS)
         $display("mismatch @%0t result %0d: %s", $time, checked_count, what);
      fail_count++;
   endtask

   // Advance the blur model by one accepted transfer.
   task automatic blur_step(input logic op, input bb3_pkg::rgb_type pix_in);
      int unsigned      w, h, pos, row_c, col_c, count;
      int unsigned      sum_r, sum_g, sum_b;
      bb3_pkg::rgb_type pix, top, mid, v;
      logic             flushing;
      blurred_type      res;
      w   = clamp_dim(width_reg, MAX_W);
      h   = clamp_dim(height_reg, MAX_H);
      pix = pix_in;
      if (in_col >= w || in_row > h + 1) restart_frame();
      flushing = (in_row >= h);
      if (!flushing && op == bb3_pkg::OP_DRAIN) return;
      if (flushing) pix = '0;

      top = upper_rows[in_col];
      mid = middle_rows[in_col];
      upper_rows[in_col]  = mid;
      middle_rows[in_col] = pix;
      for (int r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = pix;

      pos = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (pos < w + 1) return;

      row_c = out_idx / w;
      col_c = out_idx % w;
      count = 0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int dr = 0; dr < 3; dr++) begin
         if (dr == 0 && row_c == 0) continue;
         if (dr == 2 && row_c + 1 >= h) continue;
         for (int ds = 0; ds < 3; ds++) begin
            if (ds == 0 && col_c == 0) continue;
            if (ds == 2 && col_c + 1 >= w) continue;
            v = win[dr*3 + ds];
            sum_r += v.red;
            sum_g += v.green;
            sum_b += v.blue;
            count++;
         end
      end
      res.color.red   = bb3_pkg::PIX_W'((2 * sum_r + count) / (2 * count));
      res.color.green = bb3_pkg::PIX_W'((2 * sum_g + count) / (2 * count));
      res.color.blue  = bb3_pkg::PIX_W'((2 * sum_b + count) / (2 * count));
      if (out_idx + 1 >= w * h) begin
         res.frame_end = 1'b1;
         restart_frame();
      end else begin
         res.frame_end = 1'b0;
         out_idx++;
      end
      blurred_q.push_back(res);
   endtask

   // Input driver: offer the next pending item once the last one transferred.
   always @(posedge clock) begin : drive_items
      pixel_item_type nxt;
      int unsigned    gap_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         gap_pct = (idle_mode == IDLE_MOSTLY_RX) ? 13 : (idle_mode == IDLE_MOSTLY_TX) ? 85 : 0;
         if (req_valid && !req_stall)
            blur_step(req_operation, {req_in_red, req_in_green, req_in_blue});
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && !chance(gap_pct)) begin
               nxt = pending_q.pop_front();
               req_valid     <= 1'b1;
               req_operation <= nxt.op;
               req_in_red    <= nxt.pix.red;
               req_in_green  <= nxt.pix.green;
               req_in_blue   <= nxt.pix.blue;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long output hold-off, started on request.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor: compare each transfer with the oldest expectation.
   always @(posedge clock) begin : check_results
      blurred_type want;
      int unsigned stall_pct;
      if (!reset) begin
         stall_pct = (idle_mode == IDLE_MOSTLY_RX) ? 85 : (idle_mode == IDLE_MOSTLY_TX) ? 13 : 0;
         if (rsp_valid && !rsp_stall) begin
            if (blurred_q.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = blurred_q.pop_front();
               if (rsp_out_red !== want.color.red)
                  report_mismatch($sformatf("red got %0d want %0d",
                                            rsp_out_red, want.color.red));
               if (rsp_out_green !== want.color.green)
                  report_mismatch($sformatf("green got %0d want %0d",
                                            rsp_out_green, want.color.green));
               if (rsp_out_blue !== want.color.blue)
                  report_mismatch($sformatf("blue got %0d want %0d",
                                            rsp_out_blue, want.color.blue));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end got %b want %b",
                                            rsp_frame_end, want.frame_end));
            end
            checked_count++;
         end
         rsp_stall <= (hold_left != 0) || chance(stall_pct);
      end
   end

   task automatic push_item(input logic op, input bb3_pkg::rgb_type pix);
      pending_q.push_back({op, pix});
   endtask

   // Hold until everything sent has come back and the pipe has settled.
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || blurred_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [bb3_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bb3_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = val[bb3_pkg::FW_W-1:0];
      else                                 height_reg = val[bb3_pkg::FH_W-1:0];
      restart_frame();
      @(negedge clock);
   endtask

   task automatic set_frame(input logic [bb3_pkg::CSR_W-1:0] w_val,
                            input logic [bb3_pkg::CSR_W-1:0] h_val);
      wait_idle();
      write_reg(bb3_pkg::REG_FRAME_WIDTH, w_val);
      write_reg(bb3_pkg::REG_FRAME_HEIGHT, h_val);
   endtask

   // Random frames, mostly small; some cut short, some noisy.
   task automatic queue_frames(input int unsigned target);
      int unsigned pushed, w, h, w_val, h_val, frames, cut;
      pushed = 0;
      while (pushed < target) begin
         w = chance(85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
         h = chance(85) ? $urandom_range(1, 6) : $urandom_range(7, 12);
         w_val = w;
         h_val = h;
         if (chance(5)) begin
            w_val = 0;
            w     = 1;
         end
         if (chance(5)) begin
            h_val = 0;
            h     = 1;
         end
         set_frame(bb3_pkg::CSR_W'(w_val), bb3_pkg::CSR_W'(h_val));
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            cut = w * h;
            if (f == frames - 1 && chance(12)) cut = $urandom_range(1, w * h);
            for (int i = 0; i < cut; i++) begin
               if (chance(8)) push_item(bb3_pkg::OP_DRAIN, 24'($urandom));
               push_item(bb3_pkg::OP_PIXEL, 24'($urandom));
               pushed++;
            end
            // a truncated frame is abandoned by the next register write
            if (cut == w * h) begin
               for (int k = 0; k <= w; k++) begin
                  push_item(chance(25) ? bb3_pkg::OP_PIXEL : bb3_pkg::OP_DRAIN,
                            24'($urandom));
                  pushed++;
               end
            end
         end
      end
   endtask

   initial begin : timeout_watch
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      foreach (upper_rows[i]) begin
         upper_rows[i]  = '0;
         middle_rows[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      width_reg  = bb3_pkg::FW_W'(640);
      height_reg = bb3_pkg::FH_W'(480);
      restart_frame();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_mode = IDLE_MOSTLY_RX;
      // 3x3 frame: corners, edges and center with extreme channel values
      set_frame(13'd3, 13'd3);
      push_item(bb3_pkg::OP_DRAIN, 24'hFFFFFF);
      push_item(bb3_pkg::OP_PIXEL, 24'hFFFFFF);
      push_item(bb3_pkg::OP_PIXEL, 24'h000000);
      push_item(bb3_pkg::OP_PIXEL, 24'hFF0000);
      push_item(bb3_pkg::OP_PIXEL, 24'h00FF00);
      push_item(bb3_pkg::OP_DRAIN, 24'h123456);
      push_item(bb3_pkg::OP_PIXEL, 24'h0000FF);
      push_item(bb3_pkg::OP_PIXEL, 24'hAAAAAA);
      push_item(bb3_pkg::OP_PIXEL, 24'h555555);
      push_item(bb3_pkg::OP_PIXEL, 24'h010101);
      push_item(bb3_pkg::OP_PIXEL, 24'hFEFEFE);
      push_item(bb3_pkg::OP_DRAIN, 24'h000000);
      push_item(bb3_pkg::OP_PIXEL, 24'hFFFFFF);
      push_item(bb3_pkg::OP_DRAIN, 24'h000000);
      push_item(bb3_pkg::OP_DRAIN, 24'h000000);
      // single-pixel frames, then zero sizes that clamp to one
      set_frame(13'd1, 13'd1);
      push_item(bb3_pkg::OP_PIXEL, 24'hFF7F01);
      push_item(bb3_pkg::OP_DRAIN, 24'h000000);
      push_item(bb3_pkg::OP_DRAIN, 24'h000000);
      set_frame(13'd0, 13'd0);
      push_item(bb3_pkg::OP_PIXEL, 24'h00FF80);
      push_item(bb3_pkg::OP_PIXEL, 24'hFFFFFF);
      push_item(bb3_pkg::OP_DRAIN, 24'h000000);

      queue_frames(200);

      idle_mode = IDLE_MOSTLY_TX;
      // oversized width; upper write bits drop, frame cut short
      set_frame(13'h1FFF, 13'd1);
      for (int i = 0; i < 30; i++) push_item(bb3_pkg::OP_PIXEL, 24'($urandom));
      queue_frames(200);

      idle_mode = IDLE_NONE;
      // oversized height; output held off early to back up the input
      set_frame(13'd1, 13'h1FFF);
      hold_req++;
      for (int i = 0; i < 120; i++) push_item(bb3_pkg::OP_PIXEL, 24'($urandom));
      wait_idle();
      hold_req++;
      queue_frames(200);

      wait_idle();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: box_blur_3x3_rgb_core.f
+incdir+src
src/bb3_pkg.sv
src/bb3_ram.sv
src/bb3_window.sv
src/box_blur_3x3_rgb_core.sv
verif/box_blur_3x3_rgb_core_tb.sv
